FILE: rtl/ipf_weight_to_rgb_defines.svh
// Assertion macros shared by the color key RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef IPF_WEIGHT_TO_RGB_DEFINES_SVH
`define IPF_WEIGHT_TO_RGB_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define IPFRGB_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define IPFRGB_CHECK_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: rtl/ipfrgb_pkg.sv
// Shared constants and types for the inverse pole figure color key.
// No dependencies; used by the interfaces and by every module of the block but the shape lane.
package ipfrgb_pkg;

  localparam int LVL_W      = 8;              // color levels and gains
  localparam int CH_W       = 10;             // raw channel, at most 765
  localparam int NUM_W      = CH_W + LVL_W;   // channel times peak level
  localparam int OWN_GAIN   = 255;
  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = 3;

  localparam logic [LVL_W-1:0] PEAK_RESET = 8'd204;
  localparam logic [LVL_W-1:0] MIX_RESET  = 8'd23;

  localparam int SHAPE_STAGES = 3;
  localparam int MERGE_STAGES = 3;
  localparam int DIV_STAGES   = LVL_W;        // one quotient bit per stage
  localparam int PIPE_DEPTH   = SHAPE_STAGES + MERGE_STAGES + DIV_STAGES;

  typedef enum logic {
    REG_PEAK = 1'b0,
    REG_MIX  = 1'b1
  } reg_idx_t;

  // Per-pixel normalization control handed from the merge stage to the dividers.
  typedef struct packed {
    logic [CH_W-1:0] divisor;
    logic            dark;
  } norm_ctl_t;

endpackage

FILE: rtl/ipfrgb_ifs.sv
// Valid/ready channel interfaces for weight requests and color results.
// Depends on ipfrgb_pkg for the color level width.
interface ipfrgb_in_if #(parameter int WEIGHT_FRAC_BITS = 16);
  logic                      valid;
  logic                      ready;
  logic [WEIGHT_FRAC_BITS:0] weight_a;
  logic [WEIGHT_FRAC_BITS:0] weight_b;
  logic [WEIGHT_FRAC_BITS:0] weight_c;

  modport source (output valid, weight_a, weight_b, weight_c, input ready);
  modport sink (input valid, weight_a, weight_b, weight_c, output ready);
endinterface

interface ipfrgb_out_if;
  logic                            valid;
  logic                            ready;
  logic [ipfrgb_pkg::LVL_W-1:0]    red;
  logic [ipfrgb_pkg::LVL_W-1:0]    green;
  logic [ipfrgb_pkg::LVL_W-1:0]    blue;
  logic                            all_dark;

  modport source (output valid, red, green, blue, all_dark, input ready);
  modport sink (input valid, red, green, blue, all_dark, output ready);
endinterface

FILE: rtl/ipfrgb_shape_lane.sv
// One weight lane: saturation and the cubic shaping 1 - (1 - w)^3, three stages.
// Depends on nothing but its width parameter; stage enables come from the top level.
module ipfrgb_shape_lane #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic [2:0]                en,
  input  logic [WEIGHT_FRAC_BITS:0] weight,
  output logic [WEIGHT_FRAC_BITS:0] shaped
);

  localparam int F = WEIGHT_FRAC_BITS;
  localparam int W = F + 1;
  localparam logic [W-1:0] ONE = W'(1) << F;

  logic [W-1:0]   w_sat;
  logic [W-1:0]   gap;
  logic [W-1:0]   gap_d1;
  logic [2*W-1:0] sq;
  logic [2*W-1:0] hi_prod;
  logic [F+W-1:0] lo_prod;
  logic [2*W-1:0] cube;

  assign w_sat = (weight > ONE) ? ONE : weight;
  assign gap   = ONE - w_sat;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq     <= (2*W)'(gap) * (2*W)'(gap);
      gap_d1 <= gap;
    end
  end

  // Split d^2 into integer and fraction parts so d^3 / ONE^2 stays exact
  // with two narrow products instead of one wide one.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      hi_prod <= (2*W)'(sq[F +: W]) * (2*W)'(gap_d1);
      lo_prod <= (F+W)'(sq[F-1:0]) * (F+W)'(gap_d1);
    end
  end

  assign cube = hi_prod + (2*W)'(lo_prod[F +: W]);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      shaped <= ONE - cube[F +: W];
    end
  end

endmodule

FILE: rtl/ipfrgb_merge.sv
// Merge stage: cross mixing of the three shaped weights, largest channel search,
// and the numerators and divisor for normalization. Depends on ipfrgb_pkg.
module ipfrgb_merge #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic [2:0]                       en,
  input  logic [ipfrgb_pkg::LVL_W-1:0]     peak_level,
  input  logic [ipfrgb_pkg::LVL_W-1:0]     cross_mix,
  input  logic [WEIGHT_FRAC_BITS:0]        shaped [3],
  output logic [ipfrgb_pkg::NUM_W-1:0]     num [3],
  output ipfrgb_pkg::norm_ctl_t            norm
);

  localparam int F     = WEIGHT_FRAC_BITS;
  localparam int W     = F + 1;
  localparam int G_W   = F + 10;
  localparam int CH_W  = ipfrgb_pkg::CH_W;
  localparam int NUM_W = ipfrgb_pkg::NUM_W;

  logic [G_W-1:0]  own_term [3];
  logic [G_W-1:0]  mix_term [3];
  logic [CH_W-1:0] chan [3];
  logic [CH_W-1:0] max_ab;
  logic [CH_W-1:0] largest;

  for (genvar i = 0; i < 3; i++) begin : g_chan
    logic [W:0]     other_sum;
    logic [G_W-1:0] total;

    assign other_sum = (W+1)'(shaped[(i+1)%3]) + (W+1)'(shaped[(i+2)%3]);
    assign total     = own_term[i] + mix_term[i];

    always_ff @(posedge clk) begin
      if (en[0]) begin
        own_term[i] <= G_W'(shaped[i]) * G_W'(ipfrgb_pkg::OWN_GAIN);
        mix_term[i] <= G_W'(cross_mix) * G_W'(other_sum);
      end
      if (en[1]) begin
        chan[i] <= total[F +: CH_W];
      end
      if (en[2]) begin
        num[i] <= NUM_W'(chan[i]) * NUM_W'(peak_level);
      end
    end
  end

  assign max_ab  = (chan[1] > chan[0]) ? chan[1] : chan[0];
  assign largest = (chan[2] > max_ab) ? chan[2] : max_ab;

  // A dark pixel has all numerators zero; a divisor of one then yields zeros.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      norm.dark    <= (largest == '0);
      norm.divisor <= (largest == '0) ? CH_W'(1) : largest;
    end
  end

endmodule

FILE: rtl/ipfrgb_div_lane.sv
// One normalization lane: restoring division of channel*peak by the largest
// channel, one quotient bit per pipeline stage. Depends on ipfrgb_pkg.
module ipfrgb_div_lane (
  input  logic                                 clk,
  input  logic [ipfrgb_pkg::DIV_STAGES-1:0]    en,
  input  logic [ipfrgb_pkg::NUM_W-1:0]         num,
  input  logic [ipfrgb_pkg::CH_W-1:0]          divisor,
  output logic [ipfrgb_pkg::LVL_W-1:0]         quot
);

  localparam int STAGES = ipfrgb_pkg::DIV_STAGES;
  localparam int NUM_W  = ipfrgb_pkg::NUM_W;
  localparam int CH_W   = ipfrgb_pkg::CH_W;
  localparam int LVL_W  = ipfrgb_pkg::LVL_W;

  logic [NUM_W-1:0] rem    [STAGES-1];
  logic [CH_W-1:0]  dvs    [STAGES-1];
  logic [LVL_W-1:0] quot_r [STAGES];

  // The numerator never exceeds 255 times the divisor, so eight bits of
  // quotient cover it and the first trial subtract starts at bit seven.
  for (genvar j = 0; j < STAGES; j++) begin : g_step
    localparam int B = STAGES - 1 - j;
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] trial;
    logic [CH_W-1:0]  dvs_in;
    logic [LVL_W-1:0] q_in;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign dvs_in = divisor;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign dvs_in = dvs[j-1];
      assign q_in   = quot_r[j-1];
    end

    assign trial = NUM_W'(dvs_in) << B;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        quot_r[j] <= take ? (q_in | (LVL_W'(1) << B)) : q_in;
      end
    end

    if (j < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem[j] <= take ? (rem_in - trial) : rem_in;
          dvs[j] <= dvs_in;
        end
      end
    end
  end

  assign quot = quot_r[STAGES-1];

endmodule

FILE: rtl/ipf_weight_to_rgb.sv
// Inverse pole figure color key: three vertex weights in, one normalized RGB
// pixel out. The block accepts one request per clock cycle unless the pipeline is
// full and the output stalled, and returns each result in order: three stages
// of cubic shaping in the weight lanes, three stages of cross mixing and
// largest-channel search, then eight stages of restoring division, one quotient
// bit each. Empty slots in the pipeline let requests keep flowing while a result waits
// at the output. When every raw channel is zero the pixel comes out black with
// all_dark set. Registers peak_level (offset 0x0) and cross_mix (offset 0x4)
// should be written only while no request is in flight.
// Depends on ipfrgb_pkg, ipfrgb_ifs, the lane and merge modules, and the defines header.
`include "ipf_weight_to_rgb_defines.svh"

module ipf_weight_to_rgb #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ipfrgb_pkg::ADDR_W-1:0]         paddr,
  input  logic [ipfrgb_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ipfrgb_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                  pready,
  ipfrgb_in_if.sink                             pix_in,
  ipfrgb_out_if.source                          rgb_out
);

  localparam int W      = WEIGHT_FRAC_BITS + 1;
  localparam int DEPTH  = ipfrgb_pkg::PIPE_DEPTH;
  localparam int SH_N   = ipfrgb_pkg::SHAPE_STAGES;
  localparam int MG_N   = ipfrgb_pkg::MERGE_STAGES;
  localparam int DV_N   = ipfrgb_pkg::DIV_STAGES;
  localparam int LVL_W  = ipfrgb_pkg::LVL_W;
  localparam int DATA_W = ipfrgb_pkg::APB_DATA_W;

  logic [LVL_W-1:0]          peak_level;
  logic [LVL_W-1:0]          cross_mix;
  ipfrgb_pkg::reg_idx_t      reg_idx;
  logic                      cfg_write;

  logic [DEPTH-1:0]          vld;
  logic [DEPTH-1:0]          stage_en;
  logic [W-1:0]              weight [3];
  logic [W-1:0]              shaped [3];
  logic [ipfrgb_pkg::NUM_W-1:0] num [3];
  ipfrgb_pkg::norm_ctl_t     norm;
  logic [LVL_W-1:0]          quot [3];
  logic                      dark_pipe [DV_N];

  // Configuration port
  assign pready    = 1'b1;
  assign reg_idx   = ipfrgb_pkg::reg_idx_t'(paddr[ipfrgb_pkg::ADDR_W-1]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_level <= ipfrgb_pkg::PEAK_RESET;
      cross_mix  <= ipfrgb_pkg::MIX_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        ipfrgb_pkg::REG_PEAK: peak_level <= pwdata[LVL_W-1:0];
        ipfrgb_pkg::REG_MIX:  cross_mix  <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ipfrgb_pkg::REG_PEAK: prdata = DATA_W'(peak_level);
      ipfrgb_pkg::REG_MIX:  prdata = DATA_W'(cross_mix);
      default:              prdata = '0;
    endcase
  end

  // A stage moves forward unless it and every stage after it are full while
  // the output is stalled, so bubbles collapse behind a waiting result.
  for (genvar k = 0; k < DEPTH; k++) begin : g_en
    assign stage_en[k] = rgb_out.ready || !(&vld[DEPTH-1:k]);
  end

  assign pix_in.ready = stage_en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (stage_en[0]) begin
        vld[0] <= pix_in.valid;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (stage_en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign weight[0] = pix_in.weight_a;
  assign weight[1] = pix_in.weight_b;
  assign weight[2] = pix_in.weight_c;

  for (genvar i = 0; i < 3; i++) begin : g_shape
    ipfrgb_shape_lane #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_shape (
      .clk    (clk),
      .en     (stage_en[SH_N-1:0]),
      .weight (weight[i]),
      .shaped (shaped[i])
    );
  end

  ipfrgb_merge #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_merge (
    .clk        (clk),
    .en         (stage_en[SH_N+MG_N-1:SH_N]),
    .peak_level (peak_level),
    .cross_mix  (cross_mix),
    .shaped     (shaped),
    .num        (num),
    .norm       (norm)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    ipfrgb_div_lane u_div (
      .clk     (clk),
      .en      (stage_en[DEPTH-1:SH_N+MG_N]),
      .num     (num[i]),
      .divisor (norm.divisor),
      .quot    (quot[i])
    );
  end

  // The dark flag rides alongside the dividers.
  for (genvar j = 0; j < DV_N; j++) begin : g_dark
    always_ff @(posedge clk) begin
      if (stage_en[SH_N+MG_N+j]) begin
        dark_pipe[j] <= (j == 0) ? norm.dark : dark_pipe[(j == 0) ? 0 : j-1];
      end
    end
  end

  assign rgb_out.valid    = vld[DEPTH-1];
  assign rgb_out.red      = quot[0];
  assign rgb_out.green    = quot[1];
  assign rgb_out.blue     = quot[2];
  assign rgb_out.all_dark = dark_pipe[DV_N-1];

  `IPFRGB_CHECK(a_dark_is_black, rgb_out.valid && rgb_out.all_dark |-> (rgb_out.red == '0 && rgb_out.green == '0 && rgb_out.blue == '0), "dark pixel with nonzero color")
  `IPFRGB_CHECK(a_free_output_takes, !vld[DEPTH-1] |-> pix_in.ready, "request refused with output slot empty")
  `IPFRGB_CHECK(a_full_stall_refuses, (&vld) && !rgb_out.ready |-> !pix_in.ready, "request taken into a full stalled pipeline")
  `IPFRGB_CHECK_NEXT(a_accept_enters, pix_in.valid && pix_in.ready, vld[0], "accepted request did not enter the pipeline")

endmodule
